FILE: rtl/core/ftnspe_pkg.sv
`default_nettype none

package ftnspe_pkg;

  localparam int NIB_W    = 4;
  localparam int SAMPLE_W = 8;
  localparam int ACC_W    = 16;

  // one tick of the serial nibble interface
  typedef struct packed {
    logic [NIB_W-1:0] x_nibble_in;
    logic [NIB_W-1:0] y_nibble_in;
    logic             ready_req;
  } in_word_t;

  // what the tap drives out on that tick
  typedef struct packed {
    logic [NIB_W-1:0] x_nibble_out;
    logic [NIB_W-1:0] y_nibble_out;
    logic             valid_res;
  } out_word_t;

  // coefficient register write
  typedef struct packed {
    logic                we;
    logic [SAMPLE_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

FILE: rtl/core/ftnspe_tap.sv
`default_nettype none

module ftnspe_tap (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ftnspe_pkg::cfg_wr_t   cfg,
  input  wire logic                  accept,
  input  wire ftnspe_pkg::in_word_t  in_word,
  output ftnspe_pkg::out_word_t      res_word
);
  import ftnspe_pkg::*;

  typedef enum logic [2:0] {
    PH_LO   = 3'd0,
    PH_HI   = 3'd1,
    PH_MUL  = 3'd2,
    PH_TOP  = 3'd3,
    PH_WAIT = 3'd4
  } phase_t;

  phase_t              phase_r;
  logic [SAMPLE_W-1:0] coef_r;
  logic [SAMPLE_W-1:0] sample_new_r;
  logic [SAMPLE_W-1:0] sample_dly_r;
  logic [ACC_W-1:0]    partial_r;
  logic [ACC_W-1:0]    product_r;
  logic [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]    product_nxt;
  logic [ACC_W-1:0]    acc_nxt;

  assign product_nxt = ACC_W'(sample_new_r) * ACC_W'(coef_r);
  assign acc_nxt     = product_r + partial_r;

  // state and coefficient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      coef_r       <= '0;
      sample_new_r <= '0;
      sample_dly_r <= '0;
      partial_r    <= '0;
      product_r    <= '0;
      acc_r        <= '0;
    end else begin
      if (cfg.we) begin
        coef_r <= cfg.data;
      end
      if (accept) begin
        unique case (phase_r)
          PH_LO: begin
            partial_r    <= ACC_W'(in_word.y_nibble_in);
            sample_new_r <= SAMPLE_W'(in_word.x_nibble_in);
            phase_r      <= PH_HI;
          end
          PH_HI: begin
            partial_r[7:4]    <= partial_r[7:4] | in_word.y_nibble_in;
            sample_new_r[7:4] <= sample_new_r[7:4] | in_word.x_nibble_in;
            phase_r           <= PH_MUL;
          end
          PH_MUL: begin
            partial_r[11:8] <= partial_r[11:8] | in_word.y_nibble_in;
            product_r       <= product_nxt;
            phase_r         <= PH_TOP;
          end
          PH_TOP: begin
            partial_r[15:12] <= partial_r[15:12] | in_word.y_nibble_in;
            phase_r          <= PH_WAIT;
          end
          default: begin
            // wait phase: shift the sample delay and accumulate
            sample_dly_r <= sample_new_r;
            acc_r        <= acc_nxt;
            phase_r      <= in_word.ready_req ? PH_LO : PH_WAIT;
          end
        endcase
      end
    end
  end

  // serial output for the current tick
  always_comb begin
    res_word = '0;
    unique case (phase_r)
      PH_LO: begin
        res_word.x_nibble_out = sample_dly_r[3:0];
        res_word.y_nibble_out = acc_r[3:0];
      end
      PH_HI: begin
        res_word.x_nibble_out = sample_dly_r[7:4];
        res_word.y_nibble_out = acc_r[7:4];
      end
      PH_MUL: res_word.y_nibble_out = acc_r[11:8];
      PH_TOP: res_word.y_nibble_out = acc_r[15:12];
      default: res_word.valid_res = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/fir_tap_nibble_serial_pe_unit.sv
`default_nettype none

// channel   | direction | handshake          | word
// ----------+-----------+--------------------+------------------------------------
// in_       | input     | in_valid/in_stall  | x nibble, y nibble, ready request
// out_      | output    | out_valid/out_stall| x nibble, y nibble, valid flag
// cfg_      | input     | cfg_we             | 8-bit tap coefficient
//
// one word in, one word out; a word can be taken every cycle while in_stall is low
// the tap state updates and the result word is registered, in the output register
// or the skid entry, at the edge that accepts the input word
// a two-entry output buffer lets one more word in while out_stall holds a result;
// in_stall rises only when both entries are full
// rst_n is synchronous: wait phase, all state and coefficient clear, buffer empties

module fir_tap_nibble_serial_pe_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire ftnspe_pkg::in_word_t       in_word,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output ftnspe_pkg::out_word_t           out_word,
  input  wire logic                       cfg_we,
  input  wire logic [ftnspe_pkg::SAMPLE_W-1:0] cfg_wdata
);
  import ftnspe_pkg::*;

  cfg_wr_t   cfg;
  out_word_t res_word;
  logic      in_take;
  logic      out_free;

  // output register and its skid entry
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      skid_valid_r;
  out_word_t skid_word_r;

  assign cfg.we   = cfg_we;
  assign cfg.data = cfg_wdata;

  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !skid_valid_r;
  // output register can load this cycle
  assign out_free = !out_valid_r || !out_stall;

  ftnspe_tap u_tap (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .accept   (in_take),
    .in_word  (in_word),
    .res_word (res_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      // skid entry drains first; it is never loaded in the same cycle
      out_valid_r  <= skid_valid_r || in_take;
      skid_valid_r <= 1'b0;
    end else if (in_take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word_r <= skid_valid_r ? skid_word_r : res_word;
    end else if (in_take) begin
      skid_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // skid entry only holds a word behind a full output register
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full with empty output register");

  // a word taken while the output is held lands in the skid entry
  a_take_to_skid : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && in_take) |=> skid_valid_r)
    else $error("accepted word lost while output held");

  // wait-phase words carry no nibbles
  a_wait_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.valid_res) |->
      (out_word_r.x_nibble_out == '0 && out_word_r.y_nibble_out == '0))
    else $error("nibbles driven during wait phase");

endmodule

`default_nettype wire
